// ----- rtl/neighbor_table_ttl_aging_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Neighbour table assertion macros
// Shared assertion forms for the neighbour table with time-to-live aging.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_TTL_AGING_UNIT_DEFINES_SVH
`define NEIGHBOR_TABLE_TTL_AGING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/nta_pkg.sv -----
// ----------------------------------------------------------------------------
// Neighbour table package
// Transaction types, register indices and controller states of the table.
// ----------------------------------------------------------------------------
package nta_pkg;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned HOPS_W  = 8;
	localparam int unsigned LIFE_W  = 8;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [ID_W-1:0] NONE_ID = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MIS_RADIUS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TTL    = 4'd1;

	localparam logic [HOPS_W-1:0] MIS_RADIUS_RST = 8'd1;
	localparam logic [LIFE_W-1:0] MAX_TTL_RST    = 8'd3;

	typedef enum logic [1:0] {
		ACT_UPDATE,
		ACT_DELETE,
		ACT_AGE,
		ACT_LOOKUP
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [ID_W-1:0]   node_id;
		logic [ID_W-1:0]   next_hop;
		logic [HOPS_W-1:0] hop_count;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [ID_W-1:0]    gateway;
		logic [ID_W-1:0]    first_gateway;
		logic [ID_W-1:0]    lowest_id;
		logic [COUNT_W-1:0] entry_count;
		logic               insert_dropped;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_FINAL,
		ST_EMIT,
		ST_SWEEP,
		ST_RENUM,
		ST_RENUM_END,
		ST_RENUM_DRAIN
	} state_t;

endpackage

// ----- rtl/neighbor_table_ttl_aging_unit.sv -----
// ----------------------------------------------------------------------------
// Neighbour table with time-to-live aging
// Fixed-size neighbour table for one routing level, held in a single entry
// memory that is swept once per request, and again when entries were removed.
// ----------------------------------------------------------------------------
// Usage. A request transaction on req (valid/stall) carries an update, delete,
// age tick or lookup. Each request yields exactly one response transaction on
// rsp (valid/stall). Configuration writes use cfg (valid/ready) with a
// register index and eight data bits; they are taken while the table is idle.
// A request takes one read/modify/write sweep of the entry memory, one entry a
// cycle, before its response is loaded into the output register.
// When the request removed entries (a delete hit or an age tick expiry), the
// insertion ranks are then compacted: one pass over the ranks and a second
// sweep of the entry memory. A new request is taken only once the table is
// idle again, after the response and any compaction.
// The response sits in an output register, so a new request is taken while it
// waits; a stalled receiver only holds up the block when the next response is
// ready. Reset empties the table at once and loads the default registers.
// ----------------------------------------------------------------------------
`include "neighbor_table_ttl_aging_unit_defines.svh"

module neighbor_table_ttl_aging_unit #(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  nta_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output nta_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nta_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nta_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

	typedef struct packed {
		logic [ID_W-1:0]   node;
		logic [ID_W-1:0]   gateway;
		logic [HOPS_W-1:0] hops;
		logic [LIFE_W-1:0] life;
		logic [AW-1:0]     rank;
	} ent_t;

	state_t state_q, state_d;

	logic accept, rd_en, scan_issue, ren_issue, idx_inc, sweep_en, fin_en, emit_load;
	logic [AW-1:0] idx_q;
	logic idx_last;

	req_t op_q;
	logic [HOPS_W-1:0] mis_radius_q;
	logic [LIFE_W-1:0] max_ttl_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] gone_q;
	logic any_removed_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] run_q;

	logic found_q;
	logic [ID_W-1:0] gw_q;
	logic first_vld_q;
	logic [AW-1:0] first_rank_q;
	logic [ID_W-1:0] first_id_q;
	logic [ID_W-1:0] low_q;
	logic free_vld_q;
	logic [AW-1:0] free_q;

	rsp_t res_q, res_d;
	rsp_t rsp_q;
	logic rsp_valid_q;

	ent_t ent_mem [TABLE_DEPTH];
	ent_t rd_data_s1;
	logic scan_s1, ren_s1, ren_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	ent_t ent_s2;
	logic [AW-1:0] shift_mem [TABLE_DEPTH];
	logic [AW-1:0] shift_s2;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	ent_t wr_data;

	logic s1_v, s1_hit, s1_keep;
	ent_t s1_new;

	logic ins_we, drop;
	ent_t ins_ent;
	logic [CW-1:0] cnt_after;
	logic [EW-1:0] cnt_ext;

	assign idx_last  = (idx_q == LAST_IDX);
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		rd_en      = 1'b0;
		scan_issue = 1'b0;
		ren_issue  = 1'b0;
		idx_inc    = 1'b0;
		sweep_en   = 1'b0;
		fin_en     = 1'b0;
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					accept  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en      = 1'b1;
				scan_issue = 1'b1;
				idx_inc    = 1'b1;
				if (idx_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				fin_en  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					emit_load = 1'b1;
					state_d   = any_removed_q ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				sweep_en = 1'b1;
				idx_inc  = 1'b1;
				if (idx_last) begin
					state_d = ST_RENUM;
				end
			end
			ST_RENUM: begin
				rd_en     = 1'b1;
				ren_issue = 1'b1;
				idx_inc   = 1'b1;
				if (idx_last) begin
					state_d = ST_RENUM_END;
				end
			end
			ST_RENUM_END: begin
				state_d = ST_RENUM_DRAIN;
			end
			ST_RENUM_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Read, modify and write back of one entry during the request sweep.
	always_comb begin
		s1_v    = valid_q[addr_s1];
		s1_hit  = s1_v && (rd_data_s1.node == op_q.node_id);
		s1_keep = s1_v;
		s1_new  = rd_data_s1;
		case (op_q.action)
			ACT_UPDATE: begin
				if (s1_hit && (rd_data_s1.hops >= op_q.hop_count)) begin
					s1_new.gateway = op_q.next_hop;
					s1_new.hops    = op_q.hop_count;
					s1_new.life    = max_ttl_q;
				end
			end
			ACT_DELETE: begin
				if (s1_hit) begin
					s1_keep = 1'b0;
				end
			end
			ACT_AGE: begin
				if (rd_data_s1.life == '0) begin
					s1_keep = 1'b0;
				end else begin
					s1_new.life = rd_data_s1.life - 8'd1;
				end
			end
			ACT_LOOKUP: begin
				s1_new = rd_data_s1;
			end
			default: begin
				s1_new = rd_data_s1;
			end
		endcase
	end

	always_comb begin
		ins_ent.node    = op_q.node_id;
		ins_ent.gateway = op_q.next_hop;
		ins_ent.hops    = op_q.hop_count;
		ins_ent.life    = max_ttl_q;
		ins_ent.rank    = AW'(count_q);
		ins_we = fin_en && (op_q.action == ACT_UPDATE) && !found_q && free_vld_q;
		drop   = (op_q.action == ACT_UPDATE) && !found_q && !free_vld_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = s1_new;
		if (scan_s1) begin
			wr_en = s1_keep;
		end else if (ren_s2) begin
			wr_en        = valid_q[addr_s2];
			wr_addr      = addr_s2;
			wr_data      = ent_s2;
			wr_data.rank = ent_s2.rank - shift_s2;
		end else if (ins_we) begin
			wr_en   = 1'b1;
			wr_addr = free_q;
			wr_data = ins_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= ent_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_en) begin
			shift_mem[idx_q] <= AW'(run_q);
		end
		if (ren_s1) begin
			shift_s2 <= shift_mem[rd_data_s1.rank];
			ent_s2   <= rd_data_s1;
			addr_s2  <= addr_s1;
		end
		if (scan_issue || ren_issue) begin
			addr_s1 <= idx_q;
		end
		if (accept) begin
			op_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			scan_s1 <= 1'b0;
			ren_s1  <= 1'b0;
			ren_s2  <= 1'b0;
		end else begin
			if (idx_inc) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			scan_s1 <= scan_issue;
			ren_s1  <= ren_issue;
			ren_s2  <= ren_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mis_radius_q <= MIS_RADIUS_RST;
			max_ttl_q    <= MAX_TTL_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIS_RADIUS) begin
				mis_radius_q <= cfg_data;
			end else if (cfg_index == CFG_MAX_TTL) begin
				max_ttl_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			gone_q        <= '0;
			any_removed_q <= 1'b0;
			count_q       <= '0;
			run_q         <= '0;
			found_q       <= 1'b0;
			first_vld_q   <= 1'b0;
			free_vld_q    <= 1'b0;
		end else begin
			if (accept) begin
				gone_q        <= '0;
				any_removed_q <= 1'b0;
				run_q         <= '0;
				found_q       <= 1'b0;
				first_vld_q   <= 1'b0;
				free_vld_q    <= 1'b0;
			end
			if (scan_s1) begin
				if (s1_v && !s1_keep) begin
					valid_q[addr_s1]         <= 1'b0;
					gone_q[rd_data_s1.rank]  <= 1'b1;
					any_removed_q            <= 1'b1;
					count_q                  <= count_q - 1'b1;
				end else if (s1_keep) begin
					if (s1_hit) begin
						found_q <= 1'b1;
					end
					if (!first_vld_q || (rd_data_s1.rank < first_rank_q)) begin
						first_vld_q <= 1'b1;
					end
				end else if (!free_vld_q) begin
					free_vld_q <= 1'b1;
				end
			end
			if (ins_we) begin
				valid_q[free_q] <= 1'b1;
				count_q         <= count_q + 1'b1;
			end
			if (sweep_en) begin
				run_q <= run_q + CW'(gone_q[idx_q]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			low_q <= NONE_ID;
		end
		if (scan_s1) begin
			if (s1_keep) begin
				if (s1_hit) begin
					gw_q <= s1_new.gateway;
				end
				if (!first_vld_q || (rd_data_s1.rank < first_rank_q)) begin
					first_rank_q <= rd_data_s1.rank;
					first_id_q   <= rd_data_s1.node;
				end
				if ((s1_new.node < low_q) && (s1_new.hops <= mis_radius_q)) begin
					low_q <= s1_new.node;
				end
			end else if (!s1_v && !free_vld_q) begin
				free_q <= addr_s1;
			end
		end
		if (fin_en) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		cnt_after = ins_we ? count_q + 1'b1 : count_q;
		cnt_ext   = EW'(cnt_after);
		res_d.found          = found_q || ins_we;
		res_d.gateway        = found_q ? gw_q : (ins_we ? op_q.next_hop : NONE_ID);
		res_d.first_gateway  = first_vld_q ? first_id_q : (ins_we ? op_q.node_id : NONE_ID);
		res_d.lowest_id      = low_q;
		if (ins_we && (op_q.hop_count <= mis_radius_q) && (op_q.node_id < low_q)) begin
			res_d.lowest_id = op_q.node_id;
		end
		res_d.entry_count    = cnt_ext[COUNT_W-1:0];
		res_d.insert_dropped = drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_q <= res_q;
		end
	end

	`NTA_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_COUNT, "count overflow")
	`NTA_ASSERT_IMPL(a_drop_full, clk, arst_n, (state_q == ST_EMIT) && res_q.insert_dropped, count_q == FULL_COUNT, "drop with free slot")
	`NTA_ASSERT_IMPL(a_found_nonempty, clk, arst_n, (state_q == ST_EMIT) && res_q.found, count_q != '0, "found in empty table")
	`NTA_ASSERT_IMPL(a_stage_excl, clk, arst_n, scan_s1, !ren_s1 && !ren_s2, "sweep stages overlap")
	`NTA_ASSERT_NEXT(a_no_renum, clk, arst_n, emit_load && !any_removed_q, state_q == ST_IDLE, "needless compaction")

endmodule
